@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg: shared types for the point-to-triangle distance block
// Register indexes of the vertex file and the flags that travel with a query.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int NUM_EDGES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_V0X = 3'd0,
        REG_V0Y = 3'd1,
        REG_V1X = 3'd2,
        REG_V1Y = 3'd3,
        REG_V2X = 3'd4,
        REG_V2Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic in_tri;
        logic degen;
    } ptd_flags_t;

endpackage

@@ rtl/ptd_cfg.sv @@
// ----------------------------------------------------------------------------
// ptd_cfg: vertex register file
// Holds the three triangle vertices written through the configuration port.
// ----------------------------------------------------------------------------
module ptd_cfg
    import ptd_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [W-1:0]         wr_data,
    output logic signed [W-1:0]  vx [NUM_EDGES],
    output logic signed [W-1:0]  vy [NUM_EDGES]
);

    logic signed [W-1:0] vx_reg [NUM_EDGES];
    logic signed [W-1:0] vy_reg [NUM_EDGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_V0X: vx_reg[0] <= wr_data;
                REG_V0Y: vy_reg[0] <= wr_data;
                REG_V1X: vx_reg[1] <= wr_data;
                REG_V1Y: vy_reg[1] <= wr_data;
                REG_V2X: vx_reg[2] <= wr_data;
                REG_V2Y: vy_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

endmodule

@@ rtl/ptd_front.sv @@
// ----------------------------------------------------------------------------
// ptd_front: geometry front end
// Six stages: differences, products, sums, region select, magnitude squares
// and the numerator and denominator of each edge's squared distance.
// ----------------------------------------------------------------------------
module ptd_front
    import ptd_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  qx,
    input  logic signed [W-1:0]  qy,
    input  logic signed [W-1:0]  vx [NUM_EDGES],
    input  logic signed [W-1:0]  vy [NUM_EDGES],
    output logic                 out_valid,
    output ptd_flags_t           out_flags,
    output logic [4*W+3:0]       num [NUM_EDGES],
    output logic [2*W+1:0]       den [NUM_EDGES]
);

    localparam int D  = W + 1;
    localparam int P  = 2 * W + 2;
    localparam int S  = 2 * W + 3;
    localparam int M  = 2 * W + 2;
    localparam int H  = W + 1;
    localparam int NW = 4 * W + 4;
    localparam int DW = 2 * W + 2;

    typedef enum logic [1:0] {
        SEL_NEAR_A = 2'd0,
        SEL_NEAR_B = 2'd1,
        SEL_SPAN   = 2'd2
    } sel_t;

    // stage 1
    logic              v1_reg;
    logic signed [D-1:0] wx_reg [NUM_EDGES];
    logic signed [D-1:0] wy_reg [NUM_EDGES];
    logic signed [D-1:0] ex_reg [NUM_EDGES];
    logic signed [D-1:0] ey_reg [NUM_EDGES];
    logic signed [D-1:0] gx_reg, gy_reg;
    // stage 2
    logic              v2_reg;
    logic signed [P-1:0] exwx_reg [NUM_EDGES];
    logic signed [P-1:0] eywy_reg [NUM_EDGES];
    logic signed [P-1:0] exwy_reg [NUM_EDGES];
    logic signed [P-1:0] eywx_reg [NUM_EDGES];
    logic signed [P-1:0] exex_reg [NUM_EDGES];
    logic signed [P-1:0] eyey_reg [NUM_EDGES];
    logic signed [P-1:0] wxwx_reg [NUM_EDGES];
    logic signed [P-1:0] wywy_reg [NUM_EDGES];
    logic signed [P-1:0] dga_reg, dgb_reg;
    // stage 3
    logic              v3_reg;
    logic signed [S-1:0] proj_reg [NUM_EDGES];
    logic signed [S-1:0] len2_reg [NUM_EDGES];
    logic signed [S-1:0] crs_reg  [NUM_EDGES];
    logic signed [S-1:0] d2_reg   [NUM_EDGES];
    logic signed [S-1:0] dgc_reg;
    // stage 4
    logic              v4_reg;
    ptd_flags_t        f4_reg;
    ptd_flags_t        f4_next;
    sel_t              sel4_reg  [NUM_EDGES];
    sel_t              sel4_next [NUM_EDGES];
    logic [M-1:0]      mag4_reg  [NUM_EDGES];
    logic [M-1:0]      mag4_next [NUM_EDGES];
    logic signed [S-1:0] neg_crs [NUM_EDGES];
    logic [DW-1:0]     len4_reg  [NUM_EDGES];
    logic [DW-1:0]     d24_reg   [NUM_EDGES];
    // stage 5
    logic              v5_reg;
    ptd_flags_t        f5_reg;
    sel_t              sel5_reg [NUM_EDGES];
    logic [2*H-1:0]    hh_reg   [NUM_EDGES];
    logic [2*H-1:0]    hl_reg   [NUM_EDGES];
    logic [2*H-1:0]    ll_reg   [NUM_EDGES];
    logic [DW-1:0]     len5_reg [NUM_EDGES];
    logic [DW-1:0]     d25_reg  [NUM_EDGES];
    // stage 6
    logic              v6_reg;
    ptd_flags_t        f6_reg;
    logic [NW-1:0]     num_reg  [NUM_EDGES];
    logic [NW-1:0]     num_next [NUM_EDGES];
    logic [DW-1:0]     den_reg  [NUM_EDGES];
    logic [DW-1:0]     den_next [NUM_EDGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Per-edge region and magnitude, inside test from the crosses, zero-area test.
    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            neg_crs[i] = -crs_reg[i];
            mag4_next[i] = crs_reg[i][S-1] ? neg_crs[i][M-1:0] : crs_reg[i][M-1:0];
            if (proj_reg[i] <= 0 || len2_reg[i] == 0)
                sel4_next[i] = SEL_NEAR_A;
            else if (proj_reg[i] >= len2_reg[i])
                sel4_next[i] = SEL_NEAR_B;
            else
                sel4_next[i] = SEL_SPAN;
        end
        f4_next.degen  = (dgc_reg == 0);
        f4_next.in_tri = (!crs_reg[0][S-1] && !crs_reg[1][S-1] && !crs_reg[2][S-1])
                      || ((crs_reg[0][S-1] || crs_reg[0] == 0)
                       && (crs_reg[1][S-1] || crs_reg[1] == 0)
                       && (crs_reg[2][S-1] || crs_reg[2] == 0));
    end

    always_comb
    begin
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            case (sel5_reg[i])
                SEL_NEAR_A:
                begin
                    num_next[i] = NW'(d25_reg[i]);
                    den_next[i] = DW'(1);
                end
                SEL_NEAR_B:
                begin
                    num_next[i] = NW'(d25_reg[(i + 1) % NUM_EDGES]);
                    den_next[i] = DW'(1);
                end
                default:
                begin
                    num_next[i] = (NW'(hh_reg[i]) << (2 * H))
                                + (NW'(hl_reg[i]) << (H + 1))
                                + NW'(ll_reg[i]);
                    den_next[i] = len5_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                wx_reg[i] <= $signed({qx[W-1], qx}) - $signed({vx[i][W-1], vx[i]});
                wy_reg[i] <= $signed({qy[W-1], qy}) - $signed({vy[i][W-1], vy[i]});
                ex_reg[i] <= $signed({vx[(i+1)%NUM_EDGES][W-1], vx[(i+1)%NUM_EDGES]})
                           - $signed({vx[i][W-1], vx[i]});
                ey_reg[i] <= $signed({vy[(i+1)%NUM_EDGES][W-1], vy[(i+1)%NUM_EDGES]})
                           - $signed({vy[i][W-1], vy[i]});

                exwx_reg[i] <= ex_reg[i] * wx_reg[i];
                eywy_reg[i] <= ey_reg[i] * wy_reg[i];
                exwy_reg[i] <= ex_reg[i] * wy_reg[i];
                eywx_reg[i] <= ey_reg[i] * wx_reg[i];
                exex_reg[i] <= ex_reg[i] * ex_reg[i];
                eyey_reg[i] <= ey_reg[i] * ey_reg[i];
                wxwx_reg[i] <= wx_reg[i] * wx_reg[i];
                wywy_reg[i] <= wy_reg[i] * wy_reg[i];

                proj_reg[i] <= S'(exwx_reg[i]) + S'(eywy_reg[i]);
                len2_reg[i] <= S'(exex_reg[i]) + S'(eyey_reg[i]);
                crs_reg[i]  <= S'(exwy_reg[i]) - S'(eywx_reg[i]);
                d2_reg[i]   <= S'(wxwx_reg[i]) + S'(wywy_reg[i]);

                sel4_reg[i] <= sel4_next[i];
                mag4_reg[i] <= mag4_next[i];
                len4_reg[i] <= len2_reg[i][DW-1:0];
                d24_reg[i]  <= d2_reg[i][DW-1:0];

                // Square of the cross magnitude, split into halves.
                hh_reg[i]   <= mag4_reg[i][M-1:H] * mag4_reg[i][M-1:H];
                hl_reg[i]   <= mag4_reg[i][M-1:H] * mag4_reg[i][H-1:0];
                ll_reg[i]   <= mag4_reg[i][H-1:0] * mag4_reg[i][H-1:0];
                sel5_reg[i] <= sel4_reg[i];
                len5_reg[i] <= len4_reg[i];
                d25_reg[i]  <= d24_reg[i];

                num_reg[i] <= num_next[i];
                den_reg[i] <= den_next[i];
            end
            gx_reg  <= $signed({vx[2][W-1], vx[2]}) - $signed({vx[0][W-1], vx[0]});
            gy_reg  <= $signed({vy[2][W-1], vy[2]}) - $signed({vy[0][W-1], vy[0]});
            dga_reg <= ex_reg[0] * gy_reg;
            dgb_reg <= ey_reg[0] * gx_reg;
            dgc_reg <= S'(dga_reg) - S'(dgb_reg);
            f4_reg  <= f4_next;
            f5_reg  <= f4_reg;
            f6_reg  <= f5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_flags = f6_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

@@ rtl/ptd_root.sv @@
// ----------------------------------------------------------------------------
// ptd_root: pipelined rational square root
// Gives the largest q with q*q*den <= num, one result bit per stage,
// keeping q*den alongside so that each trial is a shift, add and compare.
// ----------------------------------------------------------------------------
module ptd_root
#(
    parameter int W = 16
)
(
    input  logic           clk,
    input  logic           adv,
    input  logic [4*W+3:0] num,
    input  logic [2*W+1:0] den,
    output logic [W:0]     q
);

    localparam int R = 4 * W + 6;
    localparam int N = W + 1;

    logic [R-1:0] r_reg  [N];
    logic [R-1:0] t_reg  [N];
    logic [R-1:0] d_reg  [N];
    logic [W:0]   q_reg  [N];
    logic [R-1:0] sr     [N];
    logic [R-1:0] st     [N];
    logic [R-1:0] sd     [N];
    logic [W:0]   sq     [N];
    logic [R-1:0] delta  [N];
    logic         take   [N];
    logic [R-1:0] r_next [N];
    logic [R-1:0] t_next [N];
    logic [W:0]   q_next [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                sr[k] = R'(num);
                st[k] = '0;
                sd[k] = R'(den);
                sq[k] = '0;
            end
            else
            begin
                sr[k] = r_reg[k-1];
                st[k] = t_reg[k-1];
                sd[k] = d_reg[k-1];
                sq[k] = q_reg[k-1];
            end
        end
    end

    // Stage k decides bit W-k; the remainder holds num - q*q*den.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            delta[k]  = (st[k] << (W - k + 1)) + (sd[k] << (2 * (W - k)));
            take[k]   = (delta[k] <= sr[k]);
            r_next[k] = take[k] ? sr[k] - delta[k] : sr[k];
            t_next[k] = take[k] ? st[k] + (sd[k] << (W - k)) : st[k];
            q_next[k] = sq[k];
            q_next[k][W-k] = take[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                r_reg[k] <= r_next[k];
                t_reg[k] <= t_next[k];
                d_reg[k] <= sd[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign q = q_reg[N-1];

endmodule

@@ rtl/point_triangle_distance_2d.sv @@
// ----------------------------------------------------------------------------
// point_triangle_distance_2d: distance from query points to a fixed triangle
// Write the three vertices on the cfg channel (indexes 0..5: v0x, v0y, v1x,
// v1y, v2x, v2y, signed fixed point), then stream query points in.
//
// Each accepted request on query_valid/query_ready returns one result on
// result_valid/result_ready: the distance to the closed triangle, rounded
// down, in the coordinates' fixed-point scale, and a flag that is set for a
// zero-area triangle, when the distance is all ones.
// The path has six geometry stages, COORD_WIDTH + 1 square-root stages
// (one result bit each) and the output register. One request is taken
// every cycle while the receiver is not stalling the output.
// When the receiver stalls the whole pipeline holds and query_ready falls;
// nothing is dropped or repeated. Reset clears the vertices to zero and
// empties the pipeline. cfg_ready is always high; writes are meant to be
// made while no request is in flight.
// ----------------------------------------------------------------------------
module point_triangle_distance_2d
    import ptd_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]       cfg_data,
    input  logic                         query_valid,
    output logic                         query_ready,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [COORD_WIDTH:0]         distance,
    output logic                         degenerate
);

    localparam int W = COORD_WIDTH;
    localparam int N = W + 1;

    logic signed [W-1:0] vx [NUM_EDGES];
    logic signed [W-1:0] vy [NUM_EDGES];
    logic                adv;
    logic                fr_valid;
    ptd_flags_t          fr_flags;
    logic [4*W+3:0]      num [NUM_EDGES];
    logic [2*W+1:0]      den [NUM_EDGES];
    logic [W:0]          q   [NUM_EDGES];
    logic                vld_reg [N];
    ptd_flags_t          flg_reg [N];
    logic [W:0]          qmin;
    logic                result_valid_reg;
    logic [W:0]          distance_reg;
    logic [W:0]          distance_next;
    logic                degenerate_reg;

    assign adv         = !result_valid_reg || result_ready;
    assign query_ready = adv;
    assign cfg_ready   = 1'b1;

    ptd_cfg #(.W(W)) u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .vx       (vx),
        .vy       (vy)
    );

    ptd_front #(.W(W)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (query_valid),
        .qx        (query_x),
        .qy        (query_y),
        .vx        (vx),
        .vy        (vy),
        .out_valid (fr_valid),
        .out_flags (fr_flags),
        .num       (num),
        .den       (den)
    );

    for (genvar e = 0; e < NUM_EDGES; e++)
    begin : g_edge
        ptd_root #(.W(W)) u_root
        (
            .clk (clk),
            .adv (adv),
            .num (num[e]),
            .den (den[e]),
            .q   (q[e])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
                vld_reg[k] <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= fr_valid;
            for (int k = 1; k < N; k++)
                vld_reg[k] <= vld_reg[k-1];
            result_valid_reg <= vld_reg[N-1];
        end
    end

    always_comb
    begin
        qmin = q[0];
        if (q[1] < qmin)
            qmin = q[1];
        if (q[2] < qmin)
            qmin = q[2];
        if (flg_reg[N-1].degen)
            distance_next = '1;
        else if (flg_reg[N-1].in_tri)
            distance_next = '0;
        else
            distance_next = qmin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flg_reg[0] <= fr_flags;
            for (int k = 1; k < N; k++)
                flg_reg[k] <= flg_reg[k-1];
            distance_reg   <= distance_next;
            degenerate_reg <= flg_reg[N-1].degen;
        end
    end

    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign degenerate   = degenerate_reg;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !query_ready)
        else $error("query accepted while the output is stalled");

    a_degen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |-> (&distance))
        else $error("degenerate result without saturated distance");
`endif

endmodule
